FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: request and status
// codes, fixed field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default configuration
  localparam int unsigned DefDepth = 1024;
  localparam int unsigned DefDataW = 32;

  // Fixed field widths on the stream ports
  localparam int unsigned ReqW   = 2;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 11;

  // Request codes
  localparam logic [ReqW-1:0] REQ_PUSH_BACK  = 2'd0;
  localparam logic [ReqW-1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [ReqW-1:0] REQ_POP_BACK   = 2'd2;
  localparam logic [ReqW-1:0] REQ_POP_FRONT  = 2'd3;

  // Status codes
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  // Controller command to the datapath
  typedef struct packed {
    logic load_req;  // execute the request on the input port this cycle
  } deq_cmd_t;

endpackage

FILE: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: decides when a request transaction is taken and when
// the result transaction is presented on the output channel.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_q, state_d;
  logic take;

  // A new request may enter when idle or when the pending result leaves now
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_RESP);
  assign take        = in_valid_i && in_ready_o;
  assign cmd_o.load_req = take;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i && !take) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Deque datapath: ring store, front pointer, entry count and the result
// registers. One request is executed per load command.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
  parameter int unsigned DEPTH  = DefDepth,
  parameter int unsigned DATA_W = DefDataW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deq_cmd_t          cmd_i,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [WordW-1:0]  push_word_i,
  output logic [WordW-1:0]  pop_word_o,
  output logic              pop_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [CountW-1:0] entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic              pop_valid_q, pop_valid_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [DATA_W-1:0] rd_q;

  logic [DATA_W-1:0] wr_word;
  logic [CW-1:0]     offset;
  logic [SW-1:0]     pos_sum;
  logic [AW-1:0]     back_pos;
  logic [AW-1:0]     front_inc, front_dec;
  logic [AW-1:0]     addr;
  logic              is_full, is_empty, is_pop;
  logic              wr_en, rd_en;

  // Fit the incoming word to the store width
  if (DATA_W <= WordW) begin : g_wr_trunc
    assign wr_word = push_word_i[DATA_W-1:0];
  end else begin : g_wr_ext
    assign wr_word = {{(DATA_W-WordW){1'b0}}, push_word_i};
  end

  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign is_pop   = (req_type_i == REQ_POP_BACK) || (req_type_i == REQ_POP_FRONT);

  // Back slot: front + count for push, front + count - 1 for pop (mod DEPTH)
  assign offset   = is_pop ? (count_q - CW'(1)) : count_q;
  assign pos_sum  = SW'(front_q) + SW'(offset);
  assign back_pos = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : AW'(pos_sum);

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

  // Request decode
  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    pop_valid_d = 1'b0;
    status_d    = STAT_OK;
    addr        = back_pos;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    unique case (req_type_i)
      REQ_PUSH_BACK: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        addr = front_dec;
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_en       = 1'b1;
          pop_valid_d = 1'b1;
          count_d     = count_q - CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        addr = front_q;
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_en       = 1'b1;
          pop_valid_d = 1'b1;
          front_d     = front_inc;
          count_d     = count_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Ring store, single port with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req && wr_en) mem[addr] <= wr_word;
    if (cmd_i.load_req && rd_en) rd_q <= mem[addr];
  end

  // Pointer, count and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      pop_valid_q <= 1'b0;
      status_q    <= STAT_OK;
    end else if (cmd_i.load_req) begin
      front_q     <= front_d;
      count_q     <= count_d;
      pop_valid_q <= pop_valid_d;
      status_q    <= status_d;
    end
  end

  // Result fields
  if (DATA_W >= WordW) begin : g_rd_trunc
    assign pop_word_o = pop_valid_q ? rd_q[WordW-1:0] : '0;
  end else begin : g_rd_ext
    assign pop_word_o = pop_valid_q ? {{(WordW-DATA_W){1'b0}}, rd_q} : '0;
  end

  if (CW >= CountW) begin : g_cnt_trunc
    assign entry_count_o = count_q[CountW-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(CountW-CW){1'b0}}, count_q};
  end

  assign pop_valid_o = pop_valid_q;
  assign status_o    = status_q;

endmodule

FILE: sv/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of data words in a ring buffer: push or pop at either
// end, one result transaction per request transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                    Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tdata: push_word, tuser: req_type
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata: pop_word, entry_count;
//                                                   tuser: pop_valid, status
//
// A request executes in the cycle it is taken; its result appears in the next
// cycle, from the registered read port of the ring store.
// Throughput is one transaction per cycle while m_axis takes each result at
// once; a stalled result blocks new requests until it is taken.
// Reset clears the front pointer and entry count; the store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; #(
  parameter int unsigned DEPTH  = DefDepth,
  parameter int unsigned DATA_W = DefDataW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_word
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] pop_word, [42:32] entry_count, zero pad
  output logic [2:0]  m_axis_tuser    // [0] pop_valid, [2:1] status
);

  deq_cmd_t          cmd;
  logic [WordW-1:0]  pop_word;
  logic              pop_valid;
  logic [StatW-1:0]  status;
  logic [CountW-1:0] entry_count;

  // Handshake control
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Store and pointers
  deq_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (s_axis_tuser),
    .push_word_i   (s_axis_tdata),
    .pop_word_o    (pop_word),
    .pop_valid_o   (pop_valid),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  // Pack result fields
  assign m_axis_tdata = {5'b0, entry_count, pop_word};
  assign m_axis_tuser = {status, pop_valid};

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of double_ended_queue_top. Requests (push back, push
// front, pop back, pop front) go in on s_axis with random gaps. Each accepted
// request updates a shadow ring of the queue kept here, and the reply it
// owes is queued. Replies taken on m_axis are compared field by field with
// the oldest owed reply. Runs cover empty and full corners, both ends and
// pointer wrap, a long output stall and a stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int unsigned    MaxShown = 10;
  localparam logic [WordW-1:0] WordMask = WordW'((64'd1 << DefDataW) - 64'd1);

  // One reply transaction, unpacked
  typedef struct packed {
    logic [WordW-1:0]  pop_word;
    logic              pop_valid;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] entry_count;
  } deq_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] push_word
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] pop_word, [42:32] entry_count
  logic [2:0]  m_axis_tuser;         // [0] pop_valid, [2:1] status

  // Shadow copy of the queue contents
  logic [WordW-1:0] shadow_ring [DefDepth];
  int unsigned      shadow_front = 0;
  int unsigned      shadow_count = 0;

  deq_reply_t owed_replies[$];

  int unsigned idle_pct     = 33;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned bad_replies  = 0;
  int unsigned sent_items   = 0;
  int unsigned taken_items  = 0;
  int unsigned pushes_ok    = 0;
  int unsigned pops_ok      = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned peak_count   = 0;

  double_ended_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Apply one request to the shadow queue and return the reply it causes
  function automatic deq_reply_t apply_request(input logic [ReqW-1:0]  kind,
                                               input logic [WordW-1:0] word);
    deq_reply_t r;
    int unsigned slot;
    r = '0;
    r.status = STAT_OK;
    if (kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT) begin
      if (shadow_count >= DefDepth) begin
        // full: word dropped, state unchanged
        r.status = STAT_FULL;
        full_rejects++;
      end else begin
        if (kind == REQ_PUSH_BACK) begin
          slot = (shadow_front + shadow_count) % DefDepth;
        end else begin
          shadow_front = (shadow_front + DefDepth - 1) % DefDepth;
          slot = shadow_front;
        end
        shadow_ring[slot] = word & WordMask;
        shadow_count++;
        pushes_ok++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
        empty_rejects++;
      end else begin
        if (kind == REQ_POP_BACK) begin
          shadow_count--;
          r.pop_word = shadow_ring[(shadow_front + shadow_count) % DefDepth];
        end else begin
          r.pop_word = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DefDepth;
          shadow_count--;
        end
        r.pop_valid = 1'b1;
        pops_ok++;
      end
    end
    r.entry_count = CountW'(shadow_count);
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [ReqW-1:0] kind, input logic [WordW-1:0] word);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    owed_replies.push_back(apply_request(kind, word));
    sent_items++;
  endtask

  task automatic send_random(input int unsigned push_pct);
    logic [ReqW-1:0] kind;
    if ($urandom_range(99) < push_pct) begin
      kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    end else begin
      kind = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
    end
    send_request(kind, $urandom());
  endtask

  task automatic flag_fault(input string what);
    bad_replies++;
    if (bad_replies <= MaxShown) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Compare one taken reply with the oldest owed one
  task automatic check_reply();
    deq_reply_t got;
    deq_reply_t want;
    got.pop_word    = m_axis_tdata[31:0];
    got.entry_count = m_axis_tdata[42:32];
    got.pop_valid   = m_axis_tuser[0];
    got.status      = m_axis_tuser[2:1];
    taken_items++;
    if (owed_replies.size() == 0) begin
      flag_fault($sformatf("reply with none outstanding: word %h valid %b status %0d count %0d",
                           got.pop_word, got.pop_valid, got.status, got.entry_count));
    end else begin
      want = owed_replies.pop_front();
      if (got.pop_word !== want.pop_word || got.pop_valid !== want.pop_valid ||
          got.status !== want.status || got.entry_count !== want.entry_count) begin
        flag_fault($sformatf(
          "reply %0d: exp word %h valid %b status %0d count %0d, got %h %b %0d %0d",
          taken_items, want.pop_word, want.pop_valid, want.status, want.entry_count,
          got.pop_word, got.pop_valid, got.status, got.entry_count));
      end
    end
  endtask

  // Receiver: check replies, drive tready with random idling or a long hold
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_reply();
    if (hold_off_req) begin
      hold_left    = 64;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Empty pops, both ends, front pointer wrap below zero, extreme words
  task automatic test_directed();
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK,  32'h0000_0000);
    send_request(REQ_PUSH_BACK,  32'hFFFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
    send_request(REQ_POP_FRONT,  32'h1234_5678);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_PUSH_BACK,  32'h0000_0001);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_POP_BACK,   32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK,  32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFE);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
  endtask

  // Receiver holds off while requests keep coming, so input must stall
  task automatic test_output_stall();
    hold_off_req = 1'b1;
    repeat (24) send_random(60);
  endtask

  // Mixed traffic near empty
  task automatic test_mixed_low();
    repeat (200) send_random(50);
  endtask

  // Fill to capacity at full rate, then push into a full queue
  task automatic test_fill();
    idle_pct = 0;
    while (shadow_count < DefDepth) send_random(100);
    repeat (12) send_random(100);
    idle_pct = 33;
  endtask

  // Mixed traffic near full
  task automatic test_mixed_high();
    repeat (500) send_random(50);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_stall();
    test_mixed_low();
    test_fill();
    test_mixed_high();
    s_axis_tvalid <= 1'b0;

    // Drain outstanding replies, then allow for the result latency
    for (int i = 0; i < 20000 && owed_replies.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (owed_replies.size() != 0) begin
      flag_fault($sformatf("%0d replies never arrived", owed_replies.size()));
    end

    $display("Covered %0d requests: %0d pushes, %0d pops, %0d pushes on full, %0d pops on empty",
             sent_items, pushes_ok, pops_ok, full_rejects, empty_rejects);
    $display("Peak occupancy %0d of %0d, one long output stall, %0d faulty replies",
             peak_count, DefDepth, bad_replies);
    if (bad_replies == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout after %0d requests and %0d replies", sent_items, taken_items);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
